[sv/cdfi_pkg.sv]
`default_nettype none

package cdfi_pkg;

    // Table size, neutral white at index 0 included.
    localparam int TABLE_ENTRIES = 64;
    localparam int CELLS         = TABLE_ENTRIES - 1;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int RGB_W         = 24;
    localparam int BANK_W        = 6;

    localparam logic [RGB_W-1:0] NEUTRAL_RGB = 24'hFFFFFF;

    typedef enum logic
    {
        REQ_FIND  = 1'b0,
        REQ_CLEAR = 1'b1
    } req_t;

    // Search token handed from cell to cell.
    typedef struct packed
    {
        logic              active;
        logic [RGB_W-1:0]  color;
        logic [IDX_W-1:0]  idx;      // index of the cell receiving it
        logic [CNT_W-1:0]  count;    // entries in use
        logic              found;
        logic              added;
        logic [IDX_W-1:0]  res_idx;
    } token_t;

endpackage

`default_nettype wire

[sv/cdfi_cell.sv]
`default_nettype none

module cdfi_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cdfi_pkg::token_t tok_in,
    output cdfi_pkg::token_t     tok_out
);

    logic                        active_reg;
    cdfi_pkg::token_t            tok_reg;
    cdfi_pkg::token_t            tok_next;
    logic [cdfi_pkg::RGB_W-1:0]  color_reg;
    logic                        in_use;
    logic                        hit;
    logic                        ins;

    // entries at or above count hold stale data and are never compared
    assign in_use = cdfi_pkg::CNT_W'(tok_in.idx) < tok_in.count;
    assign hit    = in_use && (color_reg == tok_in.color) && !tok_in.found;
    assign ins    = (cdfi_pkg::CNT_W'(tok_in.idx) == tok_in.count) && !tok_in.found;

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.idx   = cdfi_pkg::IDX_W'(tok_in.idx + 1'b1);
        tok_next.found = tok_in.found | hit | ins;
        tok_next.added = tok_in.added | ins;
        if (hit || ins)
        begin
            tok_next.res_idx = tok_in.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= tok_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in.active)
        begin
            tok_reg <= tok_next;
            if (ins)
            begin
                color_reg <= tok_in.color;
            end
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

endmodule

`default_nettype wire

[sv/color_dedup_find_or_insert.sv]
// Answer: a clear request or white is answered in the cycle after it is taken; any
//   other colour once the search token has walked the row of TABLE_ENTRIES-1 cells.
// Flow: one request at a time; a new request is taken once the previous
//   result is taken, so searches never overlap.
// Reset: asynchronous, active low; the table holds only neutral white after reset.
//   Stored colours are not cleared; the entry count guards against stale entries.
`default_nettype none

module color_dedup_find_or_insert
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic                            req_type,
    input  wire logic [cdfi_pkg::RGB_W-1:0]      color_rgb,
    // result channel
    output logic                                 res_valid,
    input  wire logic                            res_stall,
    output logic [cdfi_pkg::BANK_W-1:0]          entry_index,
    output logic                                 was_added,
    output logic                                 table_full
);

    // Search token chain: tok[0] is injected here, tok[CELLS] leaves the last cell.
    cdfi_pkg::token_t tok [cdfi_pkg::CELLS+1];

    logic                          busy_reg;
    logic                          busy_next;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [cdfi_pkg::CNT_W-1:0]    count_reg;
    logic [cdfi_pkg::CNT_W-1:0]    count_next;
    logic [cdfi_pkg::BANK_W-1:0]   bank_reg;
    logic                          added_reg;
    logic                          full_reg;

    logic                          accept;
    logic                          is_clear;
    logic                          is_white;
    logic                          tail_done;
    cdfi_pkg::token_t              head;
    cdfi_pkg::token_t              tail;

    // Hold off requests while a search runs or a result is still stalled.
    assign req_stall = busy_reg || (res_valid_reg && res_stall);
    assign accept    = req_valid && !req_stall;
    assign is_clear  = cdfi_pkg::req_t'(req_type) == cdfi_pkg::REQ_CLEAR;
    assign is_white  = color_rgb == cdfi_pkg::NEUTRAL_RGB;

    // Token enters at index 1; the neutral entry is never stored in a cell.
    always_comb
    begin
        head.active  = accept && !is_clear && !is_white;
        head.color   = color_rgb;
        head.idx     = cdfi_pkg::IDX_W'(1);
        head.count   = count_reg;
        head.found   = 1'b0;
        head.added   = 1'b0;
        head.res_idx = '0;
    end

    assign tok[0] = head;

    for (genvar k = 0; k < cdfi_pkg::CELLS; k++)
    begin : g_cell
        cdfi_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1])
        );
    end

    assign tail      = tok[cdfi_pkg::CELLS];
    assign tail_done = busy_reg && tail.active;

    // Control state.
    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        count_next     = count_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (is_clear)
            begin
                count_next     = cdfi_pkg::CNT_W'(1);
                res_valid_next = 1'b1;
            end
            else if (is_white)
            begin
                res_valid_next = 1'b1;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        if (tail_done)
        begin
            busy_next      = 1'b0;
            res_valid_next = 1'b1;
            if (tail.added)
            begin
                count_next = cdfi_pkg::CNT_W'(count_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            count_reg     <= cdfi_pkg::CNT_W'(1);
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
            count_reg     <= count_next;
        end
    end

    // Result payload: clear and white answer at once, a search when the token exits.
    always_ff @(posedge clk)
    begin
        if (accept && (is_clear || is_white))
        begin
            bank_reg  <= '0;
            added_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else if (tail_done)
        begin
            // no match and no free entry: table full, index 0
            bank_reg  <= tail.found ? cdfi_pkg::BANK_W'(tail.res_idx) : '0;
            added_reg <= tail.added;
            full_reg  <= !tail.found;
        end
    end

    assign res_valid   = res_valid_reg;
    assign entry_index = bank_reg;
    assign was_added   = added_reg;
    assign table_full  = full_reg;

endmodule

`default_nettype wire

[sv/cdfi_checker.sv]
`default_nettype none

module cdfi_checker
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    input  wire logic                            req_stall,
    input  wire logic                            req_type,
    input  wire logic [cdfi_pkg::RGB_W-1:0]      color_rgb,
    input  wire logic                            res_valid,
    input  wire logic                            res_stall,
    input  wire logic [cdfi_pkg::BANK_W-1:0]     entry_index,
    input  wire logic                            was_added,
    input  wire logic                            table_full
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_add_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(was_added && table_full))
        else $error("added and full both set");

    a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && table_full |-> entry_index == '0)
        else $error("full result with nonzero index");

    // clear answers next cycle with all-zero result
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_type == cdfi_pkg::REQ_CLEAR |=>
            res_valid && entry_index == '0 && !was_added && !table_full)
        else $error("clear request answered wrongly");

    // white answers next cycle at index 0
    a_white: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_type == cdfi_pkg::REQ_FIND &&
            color_rgb == cdfi_pkg::NEUTRAL_RGB |=>
            res_valid && entry_index == '0 && !was_added && !table_full)
        else $error("white request answered wrongly");

endmodule

bind color_dedup_find_or_insert cdfi_checker u_cdfi_checker (.*);

`default_nettype wire
